// ===== design/deq_pkg.sv =====
package deq_pkg;

    // Sizes fixed by the item formats.
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_type_t;

    // Outcome codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_RESP = 1'b1
    } ctrl_state_t;

    // One input item.
    typedef struct packed {
        req_type_t                req_type;
        logic signed [DATA_W-1:0] push_value;
    } request_t;

    // One result item.
    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] popped_value;
        logic                     popped_valid;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

endpackage

// ===== design/double_ended_queue.sv =====
// The accepting edge moves the controller to its response state, from which done and the
// result are registered together.
// No new item is taken while busy; busy is high in the response state that follows each
// accepted item, in which a pop's memory read returns the slot that becomes the new end.
// The receiver cannot stall: each result is valid for one cycle only.
// Reset (rst_n low, asynchronous) empties the queue; slot contents are kept.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::request_t request,
    output deq_pkg::result_t  result,
    output logic              done
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // Pointer, count and end value control.
    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result      (result),
        .done        (done),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Slot storage for the ring.
    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== design/deq_ram.sv =====
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/deq_ctrl.sv =====
module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  deq_pkg::request_t        request,
    output deq_pkg::result_t         result,
    output logic                     done,
    output logic                     ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
    output logic [deq_pkg::DATA_W-1:0] ram_wr_data,
    output logic                     ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
    input  logic [deq_pkg::DATA_W-1:0] ram_rd_data
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    ctrl_state_t       state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] rear_reg, rear_next;
    logic              fetch_front_reg, fetch_front_next;
    logic              fetch_rear_reg, fetch_rear_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    logic              popped_ok_reg, popped_ok_next;
    result_t           result_reg, result_next;
    logic              done_reg, done_next;

    logic              accept;
    logic              is_full;
    logic              is_void;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;
    logic [SW-1:0]     back_sum;
    logic [SW-1:0]     back2_sum;
    logic [AW-1:0]     back_slot;
    logic [AW-1:0]     back2_slot;

    assign accept  = start && (state_reg == CTRL_IDLE);
    assign is_full = (count_reg == CW'(DEPTH));
    assign is_void = (count_reg == '0);

    // Ring index arithmetic around the head pointer.
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign back_sum  = {1'b0, head_reg} + SW'(count_reg);
    assign back2_sum = back_sum - SW'(2);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                                : back_sum[AW-1:0];
    assign back2_slot = (back2_sum >= SW'(DEPTH)) ? AW'(back2_sum - SW'(DEPTH))
                                                  : back2_sum[AW-1:0];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= CTRL_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            fetch_front_reg <= 1'b0;
            fetch_rear_reg  <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            fetch_front_reg <= fetch_front_next;
            fetch_rear_reg  <= fetch_rear_next;
            done_reg        <= done_next;
        end
    end

    // End value caches and the result register.
    always_ff @(posedge clk)
    begin
        front_reg     <= front_next;
        rear_reg      <= rear_next;
        status_reg    <= status_next;
        popped_reg    <= popped_next;
        popped_ok_reg <= popped_ok_next;
        result_reg    <= result_next;
    end

    // Request decode, memory access and result assembly.
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        fetch_front_next = fetch_front_reg;
        fetch_rear_next  = fetch_rear_reg;
        status_next      = status_reg;
        popped_next      = popped_reg;
        popped_ok_next   = popped_ok_reg;
        result_next      = result_reg;
        done_next        = 1'b0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = head_dec;
        ram_wr_data      = request.push_value;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = head_inc;

        case (state_reg)
            CTRL_IDLE:
            begin
                if (accept)
                begin
                    state_next       = CTRL_RESP;
                    status_next      = ST_OK;
                    popped_next      = '0;
                    popped_ok_next   = 1'b0;
                    fetch_front_next = 1'b0;
                    fetch_rear_next  = 1'b0;
                    case (request.req_type)
                        REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = head_dec;
                                head_next   = head_dec;
                                count_next  = count_reg + CW'(1);
                                front_next  = request.push_value;
                                if (is_void)
                                begin
                                    rear_next = request.push_value;
                                end
                            end
                        end
                        REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = back_slot;
                                count_next  = count_reg + CW'(1);
                                rear_next   = request.push_value;
                                if (is_void)
                                begin
                                    front_next = request.push_value;
                                end
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (is_void)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                popped_next      = front_reg;
                                popped_ok_next   = 1'b1;
                                head_next        = head_inc;
                                count_next       = count_reg - CW'(1);
                                ram_rd_en        = 1'b1;
                                ram_rd_addr      = head_inc;
                                fetch_front_next = (count_reg != CW'(1));
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (is_void)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                popped_next     = rear_reg;
                                popped_ok_next  = 1'b1;
                                count_next      = count_reg - CW'(1);
                                ram_rd_en       = 1'b1;
                                ram_rd_addr     = back2_slot;
                                fetch_rear_next = (count_reg != CW'(1));
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            CTRL_RESP:
            begin
                // The slot that becomes the new end arrives from memory now.
                if (fetch_front_reg)
                begin
                    front_next = ram_rd_data;
                end
                if (fetch_rear_reg)
                begin
                    rear_next = ram_rd_data;
                end
                result_next.status       = status_reg;
                result_next.popped_value = popped_reg;
                result_next.popped_valid = popped_ok_reg;
                result_next.front_value  = is_void ? '0 : front_next;
                result_next.rear_value   = is_void ? '0 : rear_next;
                result_next.is_empty     = is_void;
                result_next.occupancy    = OCC_W'(count_reg);
                done_next                = 1'b1;
                fetch_front_next         = 1'b0;
                fetch_rear_next          = 1'b0;
                state_next               = CTRL_IDLE;
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg == CTRL_RESP);
    assign result = result_reg;
    assign done   = done_reg;

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above ring size");

    // The head pointer stays inside the ring.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer outside ring");

    // An accepted item always moves to the response state.
    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == CTRL_RESP))
        else $error("accepted item did not reach response state");

    // A result strobe only follows a response cycle.
    a_done_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == CTRL_RESP))
        else $error("result strobe without response cycle");

    // No fetch is pending while the controller is idle.
    a_fetch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CTRL_IDLE) |-> !(fetch_front_reg || fetch_rear_reg))
        else $error("memory fetch pending while idle");

endmodule
